@@ hw/rtl/gpsb_pkg.sv @@
// ----------------------------------------------------------------------------
// gpsb_pkg
// Types and constants shared by the pad bridge modules.
// ----------------------------------------------------------------------------
package gpsb_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_STROBE  = 2'd1,
    MODE_CLOCK   = 2'd2,
    MODE_PUBLISH = 2'd3
  } mode_e;

  localparam int unsigned PadW  = 16;
  localparam int unsigned BtnW  = 8;
  localparam int unsigned PhW   = 2;

  localparam logic [BtnW-1:0] AccIdle   = 8'hff;
  localparam logic [PhW-1:0]  TurboOnAt = 2'd2;

  // nes-style bit positions of the serial byte
  localparam int unsigned BtnA      = 0;
  localparam int unsigned BtnB      = 1;
  localparam int unsigned BtnSelect = 2;
  localparam int unsigned BtnStart  = 3;
  localparam int unsigned BtnUp     = 4;
  localparam int unsigned BtnDown   = 5;
  localparam int unsigned BtnLeft   = 6;
  localparam int unsigned BtnRight  = 7;

  typedef struct packed {
    mode_e             mode;
    logic [PadW-1:0]   pad_word;
    logic [PhW-1:0]    scan_phase;
  } in_beat_t;

  typedef struct packed {
    logic              data_line;
    logic [BtnW-1:0]   latched_buttons;
  } out_beat_t;

endpackage

@@ hw/rtl/gpsb_in_if.sv @@
// ----------------------------------------------------------------------------
// gpsb_in_if
// Input channel: one beat carries an item kind and a pad scan read.
// ----------------------------------------------------------------------------
interface gpsb_in_if;
  import gpsb_pkg::*;

  logic              valid;
  logic              ready;
  mode_e             mode;
  logic [PadW-1:0]   pad_word;
  logic [PhW-1:0]    scan_phase;

  modport source (output valid, output mode, output pad_word, output scan_phase,
                  input ready);
  modport sink   (input valid, input mode, input pad_word, input scan_phase,
                  output ready);
endinterface

@@ hw/rtl/gpsb_out_if.sv @@
// ----------------------------------------------------------------------------
// gpsb_out_if
// Output channel: one beat carries the serial line level and latched byte.
// ----------------------------------------------------------------------------
interface gpsb_out_if;
  import gpsb_pkg::*;

  logic              valid;
  logic              ready;
  logic              data_line;
  logic [BtnW-1:0]   latched_buttons;

  modport source (output valid, output data_line, output latched_buttons,
                  input ready);
  modport sink   (input valid, input data_line, input latched_buttons,
                  output ready);
endinterface

@@ hw/rtl/gpsb_fold.sv @@
// ----------------------------------------------------------------------------
// gpsb_fold
// Maps one active-low pad read to the accumulator bits it clears.
// ----------------------------------------------------------------------------
module gpsb_fold (
  input  logic [gpsb_pkg::PadW-1:0] pad_word_i,
  input  logic [gpsb_pkg::PhW-1:0]  scan_phase_i,
  input  logic [gpsb_pkg::PhW-1:0]  turbo_phase_i,
  output logic [gpsb_pkg::BtnW-1:0] clr_o
);
  import gpsb_pkg::*;

  logic [PadW-1:0] pressed;
  logic            three_btn;
  logic            turbo_on;

  assign pressed   = ~pad_word_i;
  // phases 0-1, or any read with id bits set, carry the three-button layout
  assign three_btn = (pad_word_i[3:0] != 4'h0) || (scan_phase_i < TurboOnAt);
  assign turbo_on  = (turbo_phase_i >= TurboOnAt);

  always_comb begin
    clr_o = '0;
    if (three_btn) begin
      clr_o[BtnUp]    = pressed[0];
      clr_o[BtnDown]  = pressed[1];
      clr_o[BtnA]     = pressed[4] | pressed[13];
      clr_o[BtnB]     = pressed[4] | pressed[12];
      clr_o[BtnStart] = pressed[5];
      clr_o[BtnLeft]  = pressed[10];
      clr_o[BtnRight] = pressed[11];
    end else begin
      clr_o[BtnA]      = pressed[4] | (turbo_on & (pressed[8] | pressed[10]));
      clr_o[BtnB]      = pressed[4] | (turbo_on & (pressed[9] | pressed[10]));
      clr_o[BtnStart]  = pressed[5];
      clr_o[BtnSelect] = pressed[11];
    end
  end

endmodule

@@ hw/rtl/gpsb_state.sv @@
// ----------------------------------------------------------------------------
// gpsb_state
// Bridge state: accumulator, latched byte, shift mask, turbo phase, line.
// ----------------------------------------------------------------------------
module gpsb_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  gpsb_pkg::in_beat_t  beat_i,
  output gpsb_pkg::out_beat_t result_o
);
  import gpsb_pkg::*;

  logic [BtnW-1:0] latched_q, latched_d;
  logic [BtnW-1:0] acc_q, acc_d;
  logic [BtnW-1:0] mask_q, mask_d;
  logic [PhW-1:0]  turbo_q, turbo_d;
  logic            line_q, line_d;
  logic [BtnW-1:0] clr;

  gpsb_fold u_fold (
    .pad_word_i    (beat_i.pad_word),
    .scan_phase_i  (beat_i.scan_phase),
    .turbo_phase_i (turbo_q),
    .clr_o         (clr)
  );

  always_comb begin
    latched_d = latched_q;
    acc_d     = acc_q;
    mask_d    = mask_q;
    turbo_d   = turbo_q;
    line_d    = line_q;
    unique case (beat_i.mode)
      MODE_SAMPLE: begin
        acc_d = acc_q & ~clr;
      end
      MODE_STROBE: begin
        mask_d  = {{(BtnW-1){1'b0}}, 1'b1};
        line_d  = latched_q[0];
        turbo_d = turbo_q + 1'b1;
      end
      MODE_CLOCK: begin
        mask_d = mask_q << 1;
        line_d = |(latched_q & mask_d);
      end
      MODE_PUBLISH: begin
        latched_d = acc_q;
        acc_d     = AccIdle;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '0;
      acc_q     <= AccIdle;
      mask_q    <= '0;
      turbo_q   <= '0;
      line_q    <= 1'b0;
    end else if (step_i) begin
      latched_q <= latched_d;
      acc_q     <= acc_d;
      mask_q    <= mask_d;
      turbo_q   <= turbo_d;
      line_q    <= line_d;
    end
  end

  assign result_o.data_line       = line_d;
  assign result_o.latched_buttons = latched_d;

endmodule

@@ hw/rtl/gamepad_to_serial_pad_bridge.sv @@
// ----------------------------------------------------------------------------
// gamepad_to_serial_pad_bridge
// Folds multiplexed pad reads into a button byte and serves it bit-serially.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_i     in   mode, pad_word, scan_phase
//  out_o    out  data_line, latched_buttons
//
// Each input beat yields exactly one output beat, through the input register and then the result register.
// One beat per cycle is sustained while out_o is ready: input register, state update, result register.
// The input register holds its beat while the result register is full and unread.
// Reset clears the state to latched 0x00, accumulator 0xff, mask 0, turbo 0.
// ----------------------------------------------------------------------------
module gamepad_to_serial_pad_bridge (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpsb_in_if.sink    in_i,
  gpsb_out_if.source out_o
);
  import gpsb_pkg::*;

  logic      in_valid_q;
  in_beat_t  in_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;
  out_beat_t result;
  logic      out_free;
  logic      step;
  logic      accept;

  assign out_free = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign accept   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept || (in_valid_q && !out_free);
      out_valid_q <= step || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_beat_q.mode       <= in_i.mode;
      in_beat_q.pad_word   <= in_i.pad_word;
      in_beat_q.scan_phase <= in_i.scan_phase;
    end
    if (step) begin
      out_beat_q <= result;
    end
  end

  gpsb_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (in_beat_q),
    .result_o (result)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.data_line       = out_beat_q.data_line;
  assign out_o.latched_buttons = out_beat_q.latched_buttons;

endmodule

@@ tb/tb_gamepad_to_serial_pad_bridge.sv @@
// ----------------------------------------------------------------------------
// tb_gamepad_to_serial_pad_bridge
// Self-checking bench for the pad bridge. A queue of pad samples, publishes,
// strobes and clocks feeds a clocked driver. A predictor keeps its own copy of
// the accumulator, latched byte, walking mask, turbo phase and line level.
// A clocked monitor checks each result beat against the oldest expected one.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_gamepad_to_serial_pad_bridge;
  timeunit 1ns;
  timeprecision 1ps;

  import gpsb_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandItems  = 700;

  typedef struct {
    in_beat_t beat;
    bit       hold;   // wait for every result before sending this beat
  } stim_t;

  logic clk_i;
  logic rst_ni;

  gpsb_in_if  in_if ();
  gpsb_out_if out_if ();

  gamepad_to_serial_pad_bridge u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predicted block state
  logic [BtnW-1:0] btn_latch;
  logic [BtnW-1:0] scan_acc;
  logic [BtnW-1:0] walk_mask;
  logic [PhW-1:0]  turbo_ph;
  logic            line_lvl;

  stim_t     stim_q[$];
  out_beat_t result_q[$];

  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned calm_in;
  int unsigned calm_out;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, and runs with none at all
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BtnW-1:0] pad_clears(logic [PadW-1:0] w, logic [PhW-1:0] ph);
    logic [BtnW-1:0] clr;
    clr = '0;
    if (w[3:0] != 4'h0 || ph < 2'd2) begin
      // three-button map
      if (!w[0])  clr[BtnUp] = 1'b1;
      if (!w[1])  clr[BtnDown] = 1'b1;
      if (!w[4])  begin clr[BtnA] = 1'b1; clr[BtnB] = 1'b1; end
      if (!w[5])  clr[BtnStart] = 1'b1;
      if (!w[10]) clr[BtnLeft] = 1'b1;
      if (!w[11]) clr[BtnRight] = 1'b1;
      if (!w[12]) clr[BtnB] = 1'b1;
      if (!w[13]) clr[BtnA] = 1'b1;
    end else begin
      // six-button map, turbo buttons gated by turbo phase
      if (!w[4])  begin clr[BtnA] = 1'b1; clr[BtnB] = 1'b1; end
      if (!w[5])  clr[BtnStart] = 1'b1;
      if (!w[11]) clr[BtnSelect] = 1'b1;
      if (turbo_ph >= TurboOnAt) begin
        if (!w[8])  clr[BtnA] = 1'b1;
        if (!w[9])  clr[BtnB] = 1'b1;
        if (!w[10]) begin clr[BtnA] = 1'b1; clr[BtnB] = 1'b1; end
      end
    end
    return clr;
  endfunction

  function automatic void predict_beat(mode_e m, logic [PadW-1:0] w, logic [PhW-1:0] ph);
    out_beat_t e;
    case (m)
      MODE_SAMPLE: begin
        scan_acc = scan_acc & ~pad_clears(w, ph);
      end
      MODE_STROBE: begin
        walk_mask = 8'h01;
        line_lvl  = btn_latch[BtnA];
        turbo_ph  = turbo_ph + 2'd1;
      end
      MODE_CLOCK: begin
        walk_mask = walk_mask << 1;
        line_lvl  = |(btn_latch & walk_mask);
      end
      default: begin
        btn_latch = scan_acc;
        scan_acc  = AccIdle;
      end
    endcase
    e.data_line       = line_lvl;
    e.latched_buttons = btn_latch;
    result_q.push_back(e);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    err_cnt++;
  endtask

  function automatic void add_beat(mode_e m, logic [PadW-1:0] w, logic [PhW-1:0] ph,
                                   bit hold = 1'b0);
    stim_t s;
    s.beat.mode       = m;
    s.beat.pad_word   = w;
    s.beat.scan_phase = ph;
    s.hold            = hold;
    stim_q.push_back(s);
  endfunction

  function automatic logic [PadW-1:0] rand_pad();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return ~(16'h1 << $urandom_range(0, 15));
      2: return ~(16'($urandom) & 16'($urandom) & 16'($urandom));
      3: return {12'($urandom), 4'h0};   // low nibble clear selects six-button map in phases 2-3
      default: return 16'hffff;
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t s;
    logic  fire;
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.mode       <= MODE_SAMPLE;
      in_if.pad_word   <= '0;
      in_if.scan_phase <= '0;
      send_gap         = 0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        predict_beat(in_if.mode, in_if.pad_word, in_if.scan_phase);
        send_gap = idle_len(calm_in);
      end
      if (!in_if.valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (stim_q.size() > 0 && !(stim_q[0].hold && result_q.size() > 0)) begin
          s = stim_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.mode       <= s.beat.mode;
          in_if.pad_word   <= s.beat.pad_word;
          in_if.scan_phase <= s.beat.scan_phase;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   = 0;
      idle_cycles  = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", out_if.latched_buttons, 0);
        end else begin
          e = result_q.pop_front();
          if (out_if.data_line !== e.data_line)
            report_mismatch("data_line", out_if.data_line, e.data_line);
          if (out_if.latched_buttons !== e.latched_buttons)
            report_mismatch("latched_buttons", out_if.latched_buttons, e.latched_buttons);
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a beat", idle_cycles);
        $display("tb_gamepad_to_serial_pad_bridge NOT OK");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = idle_len(calm_out);
      end
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned frame;
    int unsigned k;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_SAMPLE;
    in_if.pad_word   = '0;
    in_if.scan_phase = '0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    btn_latch        = 8'h00;
    scan_acc         = AccIdle;
    walk_mask        = 8'h00;
    turbo_ph         = '0;
    line_lvl         = 1'b0;
    err_cnt          = 0;
    calm_in          = 0;
    calm_out         = 0;

    // directed part
    add_beat(MODE_CLOCK, 16'hffff, 2'd0);     // clock before any strobe reads 0
    add_beat(MODE_STROBE, 16'hffff, 2'd0);    // turbo 1
    add_beat(MODE_PUBLISH, 16'hffff, 2'd0);   // idle accumulator reaches the host
    add_beat(MODE_SAMPLE, 16'h0000, 2'd0);    // everything pressed, three-button map
    add_beat(MODE_SAMPLE, 16'hffff, 2'd1);
    add_beat(MODE_SAMPLE, 16'h0000, 2'd2);    // six-button map, turbo still off
    add_beat(MODE_PUBLISH, 16'h0000, 2'd3);
    add_beat(MODE_STROBE, 16'h0000, 2'd3);    // turbo 2
    for (k = 0; k < 9; k++)                   // walk the mask out and one past
      add_beat(MODE_CLOCK, 16'h0000, 2'd3);
    add_beat(MODE_SAMPLE, 16'h0000, 2'd3);    // turbo buttons active
    add_beat(MODE_SAMPLE, 16'hfff1, 2'd2);    // nonzero low nibble forces three-button map
    add_beat(MODE_PUBLISH, 16'hffff, 2'd0);
    add_beat(MODE_STROBE, 16'hffff, 2'd0);    // turbo 3
    add_beat(MODE_CLOCK, 16'hffff, 2'd0);
    add_beat(MODE_STROBE, 16'hffff, 2'd0);    // turbo wraps to 0
    add_beat(MODE_SAMPLE, 16'hf0f0, 2'd3);    // turbo off again
    add_beat(MODE_PUBLISH, 16'hffff, 2'd0, 1'b1);

    // random part: mostly complete scan frames followed by a host read
    n_items = 0;
    frame   = 0;
    while (n_items < RandItems) begin
      if ($urandom_range(0, 6) == 0) begin
        // noise or a broken frame
        k = $urandom_range(1, 6);
        repeat (k) add_beat(mode_e'($urandom_range(0, 3)), rand_pad(),
                            PhW'($urandom_range(0, 3)));
        n_items += k;
      end else begin
        for (k = 0; k < 4; k++)
          add_beat(MODE_SAMPLE, rand_pad(), PhW'(k), (k == 0) && (frame % 12 == 11));
        add_beat(MODE_PUBLISH, rand_pad(), PhW'($urandom_range(0, 3)));
        add_beat(MODE_STROBE, rand_pad(), PhW'($urandom_range(0, 3)));
        k = $urandom_range(6, 10);
        repeat (k) add_beat(MODE_CLOCK, rand_pad(), PhW'($urandom_range(0, 3)));
        n_items += 6 + k;
        frame++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (stim_q.size() != 0 || in_if.valid || result_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_gamepad_to_serial_pad_bridge OK");
    end else begin
      $display("tb_gamepad_to_serial_pad_bridge NOT OK");
    end
    $finish;
  end

endmodule

@@ gamepad_to_serial_pad_bridge.f @@
hw/rtl/gpsb_pkg.sv
hw/rtl/gpsb_in_if.sv
hw/rtl/gpsb_out_if.sv
hw/rtl/gpsb_fold.sv
hw/rtl/gpsb_state.sv
hw/rtl/gamepad_to_serial_pad_bridge.sv
tb/tb_gamepad_to_serial_pad_bridge.sv
